>>> hw/rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 package
// Shared types and constants of the RC4 stream cipher: item kinds, controller
// states and the request bundle to the permutation store.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

  // Width of one byte lane and of the key length register.
  localparam int BYTE_W    = 8;
  localparam int KEY_LEN_W = 9;

  // The key store always holds a full 256 bytes.
  localparam int KEY_DEPTH = 256;

  // Key length after reset.
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

  // Largest key length that is taken as written.
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX = 9'd256;

  // Kind of an input item, carried on tuser.
  typedef enum logic [1:0] {
    ACT_LOAD     = 2'd0,
    ACT_SCHEDULE = 2'd1,
    ACT_CRYPT    = 2'd2
  } act_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCH_RD,
    ST_SCH_ADD,
    ST_SCH_J,
    ST_SCH_SWAP,
    ST_SCH_W2,
    ST_CR_J,
    ST_CR_SWAP,
    ST_CR_OUT
  } state_t;

  // Requests to the permutation store. Addresses are full bytes; the store
  // uses as many low bits as its depth needs.
  typedef struct packed {
    logic              clear;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_addr;
    logic              wr_en;
    logic [BYTE_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
  } perm_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/rc4_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/rc4_perm.sv
// ----------------------------------------------------------------------------
// RC4 permutation store
// Table memory with one valid bit per entry. An entry that has not been
// written since reset or since the last clear reads as its own index, which
// gives the identity permutation without a clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_perm
  import rc4_pkg::*;
#(
  parameter int STATE_SIZE = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire perm_req_t         req,
  output logic      [BYTE_W-1:0] rd_data
);

  localparam int IDX_W = $clog2(STATE_SIZE);

  logic [STATE_SIZE-1:0] vld_r;
  logic                  vld_q_r;
  logic [IDX_W-1:0]      addr_q_r;
  logic [BYTE_W-1:0]     ram_q;

  // Valid bits: cleared at reset and at the start of a key schedule.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clear) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr[IDX_W-1:0]] <= 1'b1;
    end
  end

  // Valid bit and address follow the read data through the read register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_q_r <= 1'b0;
    end else if (req.rd_en) begin
      vld_q_r <= vld_r[req.rd_addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      addr_q_r <= req.rd_addr[IDX_W-1:0];
    end
  end

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STATE_SIZE)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr[IDX_W-1:0]),
    .wr_data (req.wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr[IDX_W-1:0]),
    .rd_data (ram_q)
  );

  // Unwritten entries read as their index.
  assign rd_data = vld_q_r ? ram_q : BYTE_W'(addr_q_r);

endmodule

`default_nettype wire

>>> hw/rtl/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Key store, permutation table and PRGA controller of an RC4 byte cipher.
// ----------------------------------------------------------------------------
// Use: items arrive on the in_ stream. tuser gives the kind: load one key
// byte, run the key schedule, or crypt one data byte. Only a crypt item gives
// a result item on the out_ stream (data XOR keystream, and the keystream
// byte). Deciphering is the same operation. The user must see that the key
// length register is written on the cfg_ channel only while the block is
// idle; the block does not enforce this. 0 or anything above 256 counts
// as 256. A load item goes straight to the key store. A crypt item makes
// three dependent reads of the table memory (S[i], S[j], S[t]) and two swap
// writes; its result goes to the output register with the second write. A
// schedule item runs one step per table entry, each through the read, add,
// j and two write states. One item is worked on at a time; the next is
// taken once the controller is back in its idle state.
// Reset clears the indices, the key length to 16 and the table to identity
// (through per-entry valid bits, no sweep). If the receiver stalls, the result
// waits in the output register; a further crypt item then holds in its last
// step until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int STATE_SIZE = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [23:0]          in_tdata,   // key_index, key_byte, data_byte
  input  wire logic [1:0]           in_tuser,   // action
  // Result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic      [15:0]          out_tdata,  // result_byte, keystream_byte
  // Key length register
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [KEY_LEN_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(STATE_SIZE);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STATE_SIZE - 1);
  localparam logic [8:0]       SS9      = 9'(STATE_SIZE);

  // Sum of two table values or indices, reduced modulo the table size.
  function automatic logic [IDX_W-1:0] mod_add(input logic [8:0] a, input logic [8:0] b);
    logic [8:0] sum;
    sum = a + b;
    if (sum >= SS9) begin
      sum = sum - SS9;
    end
    return IDX_W'(sum);
  endfunction

  // Next PRGA index with wrap at the table size.
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] res;
    res = (a == IDX_LAST) ? '0 : a + IDX_W'(1);
    return res;
  endfunction

  // Key byte reduced modulo the table size: a constant table.
  logic [IDX_W-1:0] kmod_tab [KEY_DEPTH];
  for (genvar g = 0; g < KEY_DEPTH; g++) begin : g_kmod
    assign kmod_tab[g] = IDX_W'(g % STATE_SIZE);
  end

  // Input item fields.
  act_t              in_act;
  logic [BYTE_W-1:0] in_key_index;
  logic [BYTE_W-1:0] in_key_byte;
  logic [BYTE_W-1:0] in_data_byte;
  logic              in_accept;

  assign in_act       = act_t'(in_tuser);
  assign in_key_index = in_tdata[7:0];
  assign in_key_byte  = in_tdata[15:8];
  assign in_data_byte = in_tdata[23:16];
  assign in_accept    = in_tvalid && in_tready;

  // Registers.
  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     i_r, i_nxt;
  logic [IDX_W-1:0]     j_r, j_nxt;
  logic [IDX_W-1:0]     n_r, n_nxt;
  logic [BYTE_W-1:0]    kpos_r, kpos_nxt;
  logic [IDX_W-1:0]     kbm_r, kbm_nxt;
  logic [BYTE_W-1:0]    sx_r, sx_nxt;
  logic [BYTE_W-1:0]    sj_r, sj_nxt;
  logic [BYTE_W-1:0]    data_r, data_nxt;
  logic                 hit_i_r, hit_i_nxt;
  logic                 hit_j_r, hit_j_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [15:0]          out_data_r, out_data_nxt;
  logic [KEY_LEN_W-1:0] key_len_r;

  // Memory interfaces.
  perm_req_t         perm_req;
  logic [BYTE_W-1:0] perm_q;
  logic              key_rd_en;
  logic [BYTE_W-1:0] key_q;
  logic [BYTE_W-1:0] key_last;

  // Working values.
  logic [IDX_W-1:0]  i_step;
  logic [IDX_W-1:0]  j_step;
  logic [IDX_W-1:0]  t_idx;
  logic [BYTE_W-1:0] ks;

  // Key length register; always ready. The user must write it only while idle; the block does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= KEY_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      key_len_r <= cfg_data;
    end
  end

  // Last key position of one key repetition.
  assign key_last = (key_len_r == '0 || key_len_r > KEY_LEN_MAX) ?
                    8'hFF : BYTE_W'(key_len_r - 9'd1);

  // Key store: written by load items, read during the schedule.
  assign key_rd_en = (state_r == ST_SCH_RD);

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (in_accept && in_act == ACT_LOAD),
    .wr_addr (in_key_index),
    .wr_data (in_key_byte),
    .rd_en   (key_rd_en),
    .rd_addr (kpos_r),
    .rd_data (key_q)
  );

  // Permutation table.
  rc4_perm #(
    .STATE_SIZE (STATE_SIZE)
  ) u_perm (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (perm_req),
    .rd_data (perm_q)
  );

  // Keystream byte with forwarding of the swap that the table read may miss.
  always_comb begin
    priority if (hit_i_r) begin
      ks = sj_r;
    end else if (hit_j_r) begin
      ks = sx_r;
    end else begin
      ks = perm_q;
    end
  end

  // Controller: next state, datapath updates and memory requests.
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    kpos_nxt      = kpos_r;
    kbm_nxt       = kbm_r;
    sx_nxt        = sx_r;
    sj_nxt        = sj_r;
    data_nxt      = data_r;
    hit_i_nxt     = hit_i_r;
    hit_j_nxt     = hit_j_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    perm_req      = '0;
    i_step        = idx_inc(i_r);
    j_step        = mod_add(9'(j_r), 9'(perm_q));
    t_idx         = mod_add(9'(sx_r), 9'(perm_q));

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_act)
            ACT_SCHEDULE: begin
              perm_req.clear = 1'b1;
              n_nxt          = '0;
              kpos_nxt       = '0;
              j_nxt          = '0;
              state_nxt      = ST_SCH_RD;
            end
            ACT_CRYPT: begin
              i_nxt            = i_step;
              data_nxt         = in_data_byte;
              perm_req.rd_en   = 1'b1;
              perm_req.rd_addr = BYTE_W'(i_step);
              state_nxt        = ST_CR_J;
            end
            default: begin
              // Key loads go straight to the key store; unused codes are dropped.
            end
          endcase
        end
      end

      // Key schedule step: read S[n] and the key byte.
      ST_SCH_RD: begin
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = BYTE_W'(n_r);
        state_nxt        = ST_SCH_ADD;
      end

      // First half of the j update.
      ST_SCH_ADD: begin
        sx_nxt    = perm_q;
        j_nxt     = j_step;
        kbm_nxt   = kmod_tab[key_q];
        state_nxt = ST_SCH_J;
      end

      // Second half of the j update, then read S[j].
      ST_SCH_J: begin
        j_nxt            = mod_add(9'(j_r), 9'(kbm_r));
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = BYTE_W'(j_nxt);
        state_nxt        = ST_SCH_SWAP;
      end

      ST_SCH_SWAP: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = BYTE_W'(n_r);
        perm_req.wr_data = perm_q;
        state_nxt        = ST_SCH_W2;
      end

      ST_SCH_W2: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = BYTE_W'(j_r);
        perm_req.wr_data = sx_r;
        n_nxt            = n_r + IDX_W'(1);
        kpos_nxt         = (kpos_r == key_last) ? '0 : kpos_r + 8'd1;
        if (n_r == IDX_LAST) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SCH_RD;
        end
      end

      // S[i] is in; advance j and read S[j].
      ST_CR_J: begin
        sx_nxt           = perm_q;
        j_nxt            = j_step;
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = BYTE_W'(j_step);
        state_nxt        = ST_CR_SWAP;
      end

      // S[j] is in; first swap write and read of S[t].
      ST_CR_SWAP: begin
        sj_nxt           = perm_q;
        hit_i_nxt        = (t_idx == i_r);
        hit_j_nxt        = (t_idx == j_r);
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = BYTE_W'(i_r);
        perm_req.wr_data = perm_q;
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = BYTE_W'(t_idx);
        state_nxt        = ST_CR_OUT;
      end

      // Second swap write; the result goes out once the output register is free.
      ST_CR_OUT: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = BYTE_W'(j_r);
        perm_req.wr_data = sx_r;
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {ks, data_r ^ ks};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    kpos_r     <= kpos_nxt;
    kbm_r      <= kbm_nxt;
    sx_r       <= sx_nxt;
    sj_r       <= sj_nxt;
    data_r     <= data_nxt;
    hit_i_r    <= hit_i_nxt;
    hit_j_r    <= hit_j_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/rc4_chk.sv
// ----------------------------------------------------------------------------
// RC4 port checker
// Checks on the ports of the RC4 stream cipher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_chk
  import rc4_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [23:0] in_tdata,
  input wire logic [1:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  logic              crypt_acc;
  logic              load_acc;
  logic              out_acc;
  logic [1:0]        open_cnt_r;
  logic [BYTE_W-1:0] head_data_r;
  logic [BYTE_W-1:0] next_data_r;

  assign crypt_acc = in_tvalid && in_tready && (in_tuser == ACT_CRYPT);
  assign load_acc  = in_tvalid && in_tready && (in_tuser == ACT_LOAD);
  assign out_acc   = out_tvalid && out_tready;

  // Number of crypt items whose result item has not been taken yet; at most
  // one waits in the output register while the next one is worked on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_cnt_r <= '0;
    end else begin
      open_cnt_r <= open_cnt_r + 2'(crypt_acc) - 2'(out_acc);
    end
  end

  // Data bytes of the oldest and the newest of those crypt items.
  always_ff @(posedge clk) begin
    if (crypt_acc && (open_cnt_r == 2'd0 || (open_cnt_r == 2'd1 && out_acc))) begin
      head_data_r <= in_tdata[23:16];
    end else if (out_acc) begin
      head_data_r <= next_data_r;
    end
    if (crypt_acc) begin
      next_data_r <= in_tdata[23:16];
    end
  end

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // Result XOR keystream gives back the data byte of the oldest open crypt item.
  a_out_xor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[7:0] ^ out_tdata[15:8]) == head_data_r))
    else $error("result byte does not match data XOR keystream");

  // A crypt item keeps the block busy for its table accesses.
  a_crypt_busy: assert property (@(posedge clk) disable iff (!rst_n)
    crypt_acc |=> !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("item accepted during a crypt step");

  // A key load leaves the block ready for the next item.
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> in_tready)
    else $error("block busy after a key load");

  // After reset the block is idle with no result pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

endmodule

bind rc4_stream_cipher rc4_chk u_rc4_chk (.*);

`default_nettype wire

>>> tb/sv/rc4_checker.sv
// ----------------------------------------------------------------------------
// RC4 stream checker
// Watches the input, result and key length channels of the RC4 cipher, keeps
// its own copy of the key store, permutation and PRGA indices, predicts every
// result item and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_checker
  import rc4_pkg::*;
#(
  parameter int STATE_SIZE = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  input  wire logic                 in_tready,
  input  wire logic [23:0]          in_tdata,   // key_index, key_byte, data_byte
  input  wire logic [1:0]           in_tuser,   // action
  input  wire logic                 out_tvalid,
  input  wire logic                 out_tready,
  input  wire logic [15:0]          out_tdata,  // result_byte, keystream_byte
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [KEY_LEN_W-1:0] cfg_data,
  output int                        mismatches,
  output int                        outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] result_byte;
    logic [7:0] keystream_byte;
  } crypt_result_t;

  // Own copy of the cipher state.
  logic [7:0]           perm [STATE_SIZE];
  logic [7:0]           key_mem [KEY_DEPTH];
  int                   prga_i;
  int                   prga_j;
  logic [KEY_LEN_W-1:0] key_len;

  crypt_result_t        expected_results [$];

  function automatic void perm_to_identity();
    for (int n = 0; n < STATE_SIZE; n++) begin
      perm[n] = n[7:0];
    end
  endfunction

  function automatic void perm_swap(int a, int b);
    logic [7:0] tmp;
    tmp     = perm[a];
    perm[a] = perm[b];
    perm[b] = tmp;
  endfunction

  // Key schedule: identity, then STATE_SIZE mixing steps with the key
  // repeating every key_len bytes. A length of zero or above the store size
  // counts as the full store.
  function automatic void key_schedule();
    int klen;
    int j;
    klen = (key_len == '0 || key_len > KEY_LEN_MAX) ? KEY_DEPTH : int'(key_len);
    j    = 0;
    perm_to_identity();
    for (int n = 0; n < STATE_SIZE; n++) begin
      j = (j + int'(perm[n]) + int'(key_mem[n % klen])) % STATE_SIZE;
      perm_swap(n, j);
    end
    prga_i = 0;
    prga_j = 0;
  endfunction

  // One PRGA step; returns the keystream byte.
  function automatic logic [7:0] next_keystream();
    int t;
    prga_i = (prga_i + 1) % STATE_SIZE;
    prga_j = (prga_j + int'(perm[prga_i])) % STATE_SIZE;
    perm_swap(prga_i, prga_j);
    t = (int'(perm[prga_i]) + int'(perm[prga_j])) % STATE_SIZE;
    return perm[t];
  endfunction

  // Applies one accepted input item to the predicted state.
  function automatic void apply_item(logic [1:0] kind, logic [23:0] fields);
    crypt_result_t exp_item;
    logic [7:0]    ks;
    case (kind)
      ACT_LOAD: begin
        key_mem[fields[7:0]] = fields[15:8];
      end
      ACT_SCHEDULE: begin
        key_schedule();
      end
      ACT_CRYPT: begin
        ks                      = next_keystream();
        exp_item.result_byte    = fields[23:16] ^ ks;
        exp_item.keystream_byte = ks;
        expected_results.insert(expected_results.size(), exp_item);
      end
      default: begin
        // An unused kind leaves everything as it is.
      end
    endcase
  endfunction

  // Compares one returned result item with the oldest prediction.
  function automatic void check_result(logic [15:0] got);
    crypt_result_t exp_item;
    if (expected_results.size() == 0) begin
      $error("result item 0x%04h arrived with no prediction waiting", got);
      mismatches++;
      return;
    end
    exp_item = expected_results.pop_front();
    if (got[7:0] !== exp_item.result_byte) begin
      $error("result_byte: expected 0x%02h, got 0x%02h", exp_item.result_byte, got[7:0]);
      mismatches++;
    end
    if (got[15:8] !== exp_item.keystream_byte) begin
      $error("keystream_byte: expected 0x%02h, got 0x%02h",
             exp_item.keystream_byte, got[15:8]);
      mismatches++;
    end
  endfunction

  // Sample all three channels at each rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      perm_to_identity();
      prga_i     = 0;
      prga_j     = 0;
      key_len    = KEY_LEN_RESET;
      mismatches = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        key_len = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        check_result(out_tdata);
      end
      if (in_tvalid && in_tready) begin
        apply_item(in_tuser, in_tdata);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher testbench
// Drives key loads, key schedules and crypt items into the cipher under
// several key lengths, with random idling on both streams, and lets the
// checker predict and compare every result item.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rc4_stream_cipher
  import rc4_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         STATE_SIZE      = 256;
  localparam int         ITEM_TARGET     = 1900;
  localparam int         N_PHASES        = 8;
  // Bound on how long a schedule item keeps the block busy, with a margin.
  localparam int         SCHEDULE_CYCLES = 5 * STATE_SIZE + 64;
  localparam logic [1:0] ACT_UNUSED      = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [23:0]          in_tdata;   // key_index, key_byte, data_byte
  logic [1:0]           in_tuser;   // action
  logic                 out_tvalid;
  logic                 out_tready;
  logic [15:0]          out_tdata;  // result_byte, keystream_byte
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [KEY_LEN_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  int item_count;
  int key_len_now;
  int base_count;
  bit steady;
  bit key_loaded [KEY_DEPTH];

  logic [KEY_LEN_W-1:0] phase_lengths [N_PHASES] =
    '{9'd1, 9'd256, 9'd0, 9'd5, 9'd300, 9'd511, 9'd2, 9'd16};

  rc4_stream_cipher #(
    .STATE_SIZE (STATE_SIZE)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  rc4_checker #(
    .STATE_SIZE (STATE_SIZE)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: stall at random, except during the steady stretch.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= steady || ($urandom_range(99) >= 33);
    end
  end

  // Offers one item and waits for it to be taken. Valid stays high on return
  // so that a following item can go out without a gap.
  task automatic send_item(logic [1:0] kind, logic [7:0] kidx, logic [7:0] kbyte,
                           logic [7:0] dbyte);
    while (!steady && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {dbyte, kbyte, kidx};
    do @(posedge clk); while (!in_tready);
    if (kind != ACT_UNUSED) begin
      item_count++;
    end
    steady <= (item_count >= 700 && item_count < 1000);
  endtask

  task automatic load_key(logic [7:0] kidx, logic [7:0] kbyte);
    send_item(ACT_LOAD, kidx, kbyte, 8'($urandom));
    key_loaded[kidx] = 1'b1;
  endtask

  // Every key byte that the schedule will read is loaded first.
  task automatic run_schedule();
    for (int n = 0; n < key_len_now; n++) begin
      if (!key_loaded[n]) begin
        load_key(n[7:0], 8'($urandom));
      end
    end
    send_item(ACT_SCHEDULE, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic crypt_byte(logic [7:0] dbyte);
    send_item(ACT_CRYPT, 8'($urandom), 8'($urandom), dbyte);
  endtask

  // An item outside any well-formed message.
  task automatic noise_item();
    case ($urandom_range(2))
      0: send_item(ACT_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
      1: load_key(8'($urandom), 8'($urandom));
      default: crypt_byte(8'($urandom));
    endcase
  endtask

  // Holds the sender back until every predicted result has come.
  task automatic wait_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Writes the key length once the block has finished any schedule.
  task automatic write_key_len(logic [KEY_LEN_W-1:0] value);
    wait_results();
    repeat (SCHEDULE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    key_len_now = (value == '0 || value > KEY_LEN_MAX) ? KEY_DEPTH : int'(value);
  endtask

  // One message: mostly a rekey, a schedule and a run of crypt items, with
  // stray items mixed in; otherwise a short burst of noise.
  task automatic message_burst();
    int n_rekey;
    int n_crypt;
    if ($urandom_range(99) < 75) begin
      n_rekey = ($urandom_range(9) == 0) ? key_len_now : $urandom_range(4);
      repeat (n_rekey) load_key(8'($urandom_range(key_len_now - 1)), 8'($urandom));
      run_schedule();
      n_crypt = $urandom_range(4, 48);
      repeat (n_crypt) begin
        if ($urandom_range(19) == 0) begin
          noise_item();
        end else begin
          crypt_byte(8'($urandom));
        end
      end
    end else begin
      repeat ($urandom_range(1, 6)) noise_item();
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= ACT_LOAD;
    in_tdata   <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    steady     <= 1'b0;
    item_count  = 0;
    key_len_now = int'(KEY_LEN_RESET);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Crypt on the identity table straight after reset, and an unused kind.
    crypt_byte(8'h00);
    crypt_byte(8'hFF);
    send_item(ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF);
    // Key of the reset length with extreme bytes, plus the top key position.
    load_key(8'd0, 8'hFF);
    load_key(8'd1, 8'h00);
    for (int n = 2; n < 16; n++) begin
      load_key(n[7:0], 8'($urandom));
    end
    load_key(8'hFF, 8'hA5);
    run_schedule();
    crypt_byte(8'h00);
    crypt_byte(8'hFF);
    repeat (3) crypt_byte(8'($urandom));

    // Random messages under each key length.
    base_count = item_count;
    for (int p = 0; p < N_PHASES; p++) begin
      write_key_len(KEY_LEN_W'((p == N_PHASES - 1) ? $urandom_range(1, 256) :
                               phase_lengths[p]));
      while (item_count < base_count + (p + 1) * ITEM_TARGET / N_PHASES) begin
        message_burst();
      end
    end

    wait_results();
    repeat (SCHEDULE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
